// File: hw/rtl/lz77wd_pkg.sv
// Shared types and constants of the LZ77 window decoder.
package lz77wd_pkg;

  // History window
  localparam int unsigned WinDepth = 4096;
  localparam int unsigned WinAw    = $clog2(WinDepth);
  // Saturating produced count covers every legal back distance
  localparam int unsigned CntW     = WinAw + 1;

  // Command queue between parser and executor
  localparam int unsigned QDepth   = 4;
  localparam int unsigned QAw      = $clog2(QDepth);

  // Token fields
  localparam logic [4:0]  LenBias  = 5'd3;
  localparam logic [3:0]  FlagCnt  = 4'd8;

  // Parser phases
  typedef enum logic [6:0] {
    PH_IDLE  = 7'b0000001,
    PH_SIZE0 = 7'b0000010,
    PH_SIZE1 = 7'b0000100,
    PH_SIZE2 = 7'b0001000,
    PH_FLAG  = 7'b0010000,
    PH_DATA  = 7'b0100000,
    PH_TOKLO = 7'b1000000
  } phase_e;

  // Executor states
  typedef enum logic [2:0] {
    BK_IDLE  = 3'b001,
    BK_READ  = 3'b010,
    BK_WRITE = 3'b100
  } back_state_e;

  // One parsed input byte that produces output
  typedef struct packed {
    logic        lit;       // literal byte, else back copy
    logic        first;     // first command of a stream
    logic        last_cmd;  // command ends the stream
    logic [4:0]  len;       // bytes to emit, 1..18
    logic [11:0] dist_m1;   // back distance minus one
    logic [7:0]  data;      // literal byte
  } cmd_t;

  // One output transaction
  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       stream_last;
    logic       bad_ref;
  } out_t;

endpackage

// File: hw/rtl/lz77wd_ram.sv
// Generic simple dual-port RAM with registered read.
module lz77wd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port, then registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/lz77wd_front.sv
// Stream parser: header, flag bytes and tokens turned into commands.
module lz77wd_front #(
  parameter int unsigned SIZE_BITS = 24
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        in_byte_i,
  input  logic              stream_start_i,
  output logic              push_o,
  output lz77wd_pkg::cmd_t  cmd_o,
  input  logic              full_i
);

  lz77wd_pkg::phase_e     phase_q, phase_d;
  logic [7:0]             flags_q, flags_d;
  logic [3:0]             left_q, left_d;
  logic [SIZE_BITS-1:0]   rem_q, rem_d;
  logic [15:0]            hdr_q, hdr_d;
  logic [7:0]             hi_q, hi_d;
  logic                   first_q, first_d;

  logic                   accept;
  logic [31:0]            size_wide;
  logic                   size_over;
  logic [4:0]             tok_len;
  logic [SIZE_BITS-1:0]   tok_len_w;
  logic [4:0]             eff_len;
  logic [SIZE_BITS-1:0]   rem_after;
  logic [7:0]             flags_sh;
  logic [3:0]             left_dec;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;

  // Header size, saturated to the counter width
  assign size_wide = {8'h00, in_byte_i, hdr_q};
  assign size_over = (size_wide >> SIZE_BITS) != 32'd0;

  // Token length clipped to what the stream still owes
  assign tok_len   = {1'b0, hi_q[7:4]} + lz77wd_pkg::LenBias;
  assign tok_len_w = SIZE_BITS'(tok_len);
  assign eff_len   = (rem_q < tok_len_w) ? rem_q[4:0] : tok_len;
  assign rem_after = hi_q[7] || phase_q == lz77wd_pkg::PH_TOKLO
                     ? rem_q - SIZE_BITS'(eff_len) : rem_q;

  assign flags_sh = {flags_q[6:0], 1'b0};
  assign left_dec = (left_q != 4'd0) ? left_q - 4'd1 : left_q;

  // Parse one transaction
  always_comb begin
    phase_d = phase_q;
    flags_d = flags_q;
    left_d  = left_q;
    rem_d   = rem_q;
    hdr_d   = hdr_q;
    hi_d    = hi_q;
    first_d = first_q;
    push_o  = 1'b0;
    cmd_o   = '0;
    cmd_o.first   = first_q;
    cmd_o.dist_m1 = {hi_q[3:0], in_byte_i};
    cmd_o.data    = in_byte_i;

    if (accept) begin
      if (stream_start_i) begin
        phase_d = lz77wd_pkg::PH_SIZE0;
        flags_d = '0;
        left_d  = '0;
        rem_d   = '0;
        hi_d    = '0;
        first_d = 1'b1;
      end else begin
        unique case (phase_q)
          lz77wd_pkg::PH_IDLE: begin
            // drop stray bytes
          end
          lz77wd_pkg::PH_SIZE0: begin
            hdr_d[7:0] = in_byte_i;
            phase_d    = lz77wd_pkg::PH_SIZE1;
          end
          lz77wd_pkg::PH_SIZE1: begin
            hdr_d[15:8] = in_byte_i;
            phase_d     = lz77wd_pkg::PH_SIZE2;
          end
          lz77wd_pkg::PH_SIZE2: begin
            rem_d   = size_over ? '1 : size_wide[SIZE_BITS-1:0];
            phase_d = (size_wide == 32'd0) ? lz77wd_pkg::PH_IDLE : lz77wd_pkg::PH_FLAG;
          end
          lz77wd_pkg::PH_FLAG: begin
            flags_d = in_byte_i;
            left_d  = lz77wd_pkg::FlagCnt;
            phase_d = lz77wd_pkg::PH_DATA;
          end
          lz77wd_pkg::PH_DATA, lz77wd_pkg::PH_TOKLO: begin
            if (phase_q == lz77wd_pkg::PH_DATA && flags_q[7]) begin
              // hold the token's first byte
              hi_d    = in_byte_i;
              phase_d = lz77wd_pkg::PH_TOKLO;
            end else begin
              if (phase_q == lz77wd_pkg::PH_DATA) begin
                cmd_o.lit = 1'b1;
                cmd_o.len = 5'd1;
                rem_d     = rem_q - SIZE_BITS'(1);
              end else begin
                cmd_o.lit = 1'b0;
                cmd_o.len = eff_len;
                rem_d     = rem_after;
              end
              cmd_o.last_cmd = (rem_d == '0);
              push_o  = 1'b1;
              first_d = 1'b0;
              flags_d = flags_sh;
              left_d  = left_dec;
              if (rem_d == '0) begin
                phase_d = lz77wd_pkg::PH_IDLE;
              end else if (left_dec == 4'd0) begin
                phase_d = lz77wd_pkg::PH_FLAG;
              end else begin
                phase_d = lz77wd_pkg::PH_DATA;
              end
            end
          end
          default: phase_d = lz77wd_pkg::PH_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= lz77wd_pkg::PH_IDLE;
      flags_q <= '0;
      left_q  <= '0;
      rem_q   <= '0;
      hi_q    <= '0;
      first_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      flags_q <= flags_d;
      left_q  <= left_d;
      rem_q   <= rem_d;
      hi_q    <= hi_d;
      first_q <= first_d;
    end
  end

  // Header low bytes carry no reset
  always_ff @(posedge clk_i) begin
    hdr_q <= hdr_d;
  end

endmodule

// File: hw/rtl/lz77wd_fifo.sv
// Command queue between parser and executor.
module lz77wd_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  lz77wd_pkg::cmd_t cmd_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output lz77wd_pkg::cmd_t cmd_o
);

  localparam int unsigned Aw = lz77wd_pkg::QAw;

  lz77wd_pkg::cmd_t  mem_q [lz77wd_pkg::QDepth];
  logic [Aw-1:0]     wptr_q, rptr_q;
  logic [Aw:0]       cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == (Aw+1)'(lz77wd_pkg::QDepth));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= cmd_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= wptr_q + Aw'(1);
      end
      if (do_pop) begin
        rptr_q <= rptr_q + Aw'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + (Aw+1)'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - (Aw+1)'(1);
      end
    end
  end

endmodule

// File: hw/rtl/lz77wd_back.sv
// Executor: expands commands through the history window into output bytes.
module lz77wd_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cmd_valid_i,
  input  lz77wd_pkg::cmd_t cmd_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output lz77wd_pkg::out_t out_o
);

  localparam int unsigned Aw = lz77wd_pkg::WinAw;
  localparam int unsigned Cw = lz77wd_pkg::CntW;

  lz77wd_pkg::back_state_e state_q, state_d;
  lz77wd_pkg::cmd_t        cur_q, cur_d;
  logic [Aw-1:0]           wp_q, wp_d;
  logic [Cw-1:0]           cnt_q, cnt_d;
  logic                    bad_q, bad_d;
  logic                    ovalid_q, ovalid_d;
  lz77wd_pkg::out_t        out_q, out_d;

  logic                    out_free;
  logic                    rd_en;
  logic [Aw-1:0]           rd_addr;
  logic [7:0]              rd_data;
  logic                    wr_en;
  logic [7:0]              wr_byte;

  lz77wd_ram #(
    .WIDTH (8),
    .DEPTH (lz77wd_pkg::WinDepth)
  ) u_win (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wp_q),
    .wdata_i (wr_byte),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  assign out_free = !ovalid_q || out_ready_i;
  assign rd_addr  = wp_q - cur_q.dist_m1 - Aw'(1);

  // Byte to emit and store
  always_comb begin
    if (cur_q.lit) begin
      wr_byte = cur_q.data;
    end else if (bad_q) begin
      wr_byte = 8'h00;
    end else begin
      wr_byte = rd_data;
    end
  end

  // Sequence one command byte by byte
  always_comb begin
    state_d  = state_q;
    cur_d    = cur_q;
    wp_d     = wp_q;
    cnt_d    = cnt_q;
    bad_d    = bad_q;
    ovalid_d = ovalid_q;
    out_d    = out_q;
    pop_o    = 1'b0;
    rd_en    = 1'b0;
    wr_en    = 1'b0;

    if (ovalid_q && out_ready_i) begin
      ovalid_d = 1'b0;
    end

    unique case (state_q)
      lz77wd_pkg::BK_IDLE: begin
        if (cmd_valid_i) begin
          pop_o = 1'b1;
          cur_d = cmd_i;
          bad_d = 1'b0;
          if (cmd_i.first) begin
            wp_d  = '0;
            cnt_d = '0;
          end
          state_d = cmd_i.lit ? lz77wd_pkg::BK_WRITE : lz77wd_pkg::BK_READ;
        end
      end
      lz77wd_pkg::BK_READ: begin
        rd_en   = 1'b1;
        bad_d   = {1'b0, cur_q.dist_m1} >= cnt_q;
        state_d = lz77wd_pkg::BK_WRITE;
      end
      lz77wd_pkg::BK_WRITE: begin
        if (out_free) begin
          wr_en             = 1'b1;
          ovalid_d          = 1'b1;
          out_d.data        = wr_byte;
          out_d.run_last    = (cur_q.len == 5'd1);
          out_d.stream_last = (cur_q.len == 5'd1) && cur_q.last_cmd;
          out_d.bad_ref     = !cur_q.lit && bad_q;
          wp_d              = wp_q + Aw'(1);
          cnt_d             = cnt_q[Cw-1] ? cnt_q : cnt_q + Cw'(1);
          cur_d.len         = cur_q.len - 5'd1;
          state_d = (cur_q.len == 5'd1) ? lz77wd_pkg::BK_IDLE : lz77wd_pkg::BK_READ;
        end
      end
      default: state_d = lz77wd_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= lz77wd_pkg::BK_IDLE;
      wp_q     <= '0;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      wp_q     <= wp_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    bad_q <= bad_d;
    out_q <= out_d;
  end

  assign out_valid_o = ovalid_q;
  assign out_o       = out_q;

endmodule

// File: hw/rtl/lz77_window_decoder_core.sv
// LZ77 window decoder top level: parser, command queue and executor.
//
// Input stream (s_axis): one compressed byte per transaction in tdata;
// tuser high marks the marker byte that opens a stream. A 3-byte
// little-endian output size follows, then flag bytes, literals and
// 2-byte tokens. Bytes outside a stream are dropped.
// Output stream (m_axis): one decompressed byte per transaction; tlast
// closes the bytes produced by one input byte, tuser flags the last byte
// of the stream and copies that reach before its start (byte is zero).
// The parser takes one byte per cycle while the 4-entry command queue has
// room. The executor takes a literal through its idle and write states;
// a copy takes each byte through a window RAM read and then a write, so a
// copy may read the byte it wrote just before. In an empty pipeline a
// literal byte passes the command queue, the executor's write state and
// the output register; a token's copy adds the read state before the write.
// A stalled receiver holds the output register; the executor and then the
// queue fill and s_axis_tready drops. Reset empties the queue and returns
// the parser to waiting for a stream start; the window needs no clearing.
module lz77_window_decoder_core #(
  parameter int unsigned SIZE_BITS = 24
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tuser,   // [0] stream_start
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast,   // run_last
  output logic [1:0] m_axis_tuser    // [0] stream_last, [1] bad_reference
);

  logic             push, full, pop, q_valid;
  lz77wd_pkg::cmd_t push_cmd, q_cmd;
  lz77wd_pkg::out_t out;

  lz77wd_front #(
    .SIZE_BITS (SIZE_BITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .in_byte_i      (s_axis_tdata),
    .stream_start_i (s_axis_tuser),
    .push_o         (push),
    .cmd_o          (push_cmd),
    .full_i         (full)
  );

  lz77wd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .cmd_o   (q_cmd)
  );

  lz77wd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_cmd),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (out)
  );

  assign m_axis_tdata = out.data;
  assign m_axis_tlast = out.run_last;
  assign m_axis_tuser = {out.bad_ref, out.stream_last};

endmodule

// File: tb/lz77_window_decoder_core_tb.sv
// Self-checking testbench for the LZ77 window decoder core with random stream traffic.
module lz77_window_decoder_core_tb;

  localparam int unsigned SizeBits      = 24;
  localparam int unsigned ClkPeriod     = 12;
  localparam int unsigned WinDepth      = lz77wd_pkg::WinDepth;
  localparam int unsigned WinAw         = lz77wd_pkg::WinAw;
  // Quiet cycles that count as drained: pipeline latency plus margin
  localparam int unsigned SettleCycles  = 12;
  localparam int unsigned TimeoutCycles = 400000;

  typedef enum logic [0:0] {
    EV_BYTE,
    EV_HOLD
  } feed_kind_e;

  // One entry of the stimulus queue: a compressed byte or a drain-and-retune hold
  typedef struct {
    feed_kind_e  kind;
    logic [7:0]  data;
    logic        start;
    int unsigned send_pct;
    int unsigned recv_pct;
  } feed_t;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = 8'h00;
  logic       s_axis_tuser  = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tlast;
  logic [1:0] m_axis_tuser;

  feed_t            compressed_q[$];
  lz77wd_pkg::out_t decoded_q[$];
  int unsigned      stream_item_cnt = 0;
  int unsigned      send_idle_pct   = 0;
  int unsigned      recv_stall_pct  = 0;
  int unsigned      quiet_cnt       = 0;
  int unsigned      mismatch_cnt    = 0;
  lz77wd_pkg::out_t beat_got;
  lz77wd_pkg::out_t beat_want;

  // Decoder state mirrored by the predictor
  logic [7:0]          window [WinDepth];
  logic [WinAw-1:0]    win_wr_ptr;
  logic [SizeBits-1:0] total_len;
  logic [SizeBits-1:0] produced_len;
  logic [7:0]          flag_byte;
  logic [3:0]          flag_left;
  logic [7:0]          token_hi;
  lz77wd_pkg::phase_e  parse_phase;

  lz77_window_decoder_core #(
    .SIZE_BITS(SizeBits)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Write one output byte to the window and queue it as a decoded transaction
  function automatic void put_byte(input logic [7:0] b, input logic bad);
    window[win_wr_ptr] = b;
    win_wr_ptr   = win_wr_ptr + 1'b1;
    produced_len = produced_len + 1'b1;
    decoded_q.push_back('{data: b, run_last: 1'b0,
                          stream_last: (produced_len == total_len), bad_ref: bad});
  endfunction

  // Consume one flag bit and pick the next parse phase
  function automatic void advance_flags();
    flag_byte = flag_byte << 1;
    if (flag_left != 4'd0) flag_left = flag_left - 1'b1;
    if (produced_len == total_len) parse_phase = lz77wd_pkg::PH_IDLE;
    else if (flag_left == 4'd0) parse_phase = lz77wd_pkg::PH_FLAG;
    else parse_phase = lz77wd_pkg::PH_DATA;
  endfunction

  // Decode one accepted compressed byte into the bytes it releases
  function automatic void decode_byte(input logic [7:0] in_b, input logic start);
    int unsigned n;
    int unsigned back_dist;
    int unsigned len;
    int unsigned j;
    logic [7:0]  v;
    logic        bad;
    n = 0;
    if (start) begin
      win_wr_ptr   = '0;
      total_len    = '0;
      produced_len = '0;
      flag_byte    = '0;
      flag_left    = '0;
      token_hi     = '0;
      parse_phase  = lz77wd_pkg::PH_SIZE0;
      return;
    end
    case (parse_phase)
      lz77wd_pkg::PH_SIZE0: begin
        total_len[7:0] = in_b;
        parse_phase = lz77wd_pkg::PH_SIZE1;
      end
      lz77wd_pkg::PH_SIZE1: begin
        total_len[15:8] = in_b;
        parse_phase = lz77wd_pkg::PH_SIZE2;
      end
      lz77wd_pkg::PH_SIZE2: begin
        total_len[23:16] = in_b;
        parse_phase = (total_len == '0) ? lz77wd_pkg::PH_IDLE : lz77wd_pkg::PH_FLAG;
      end
      lz77wd_pkg::PH_FLAG: begin
        flag_byte   = in_b;
        flag_left   = lz77wd_pkg::FlagCnt;
        parse_phase = lz77wd_pkg::PH_DATA;
      end
      lz77wd_pkg::PH_DATA: begin
        if (flag_byte[7]) begin
          token_hi    = in_b;
          parse_phase = lz77wd_pkg::PH_TOKLO;
        end else begin
          put_byte(in_b, 1'b0);
          n = 1;
          advance_flags();
        end
      end
      lz77wd_pkg::PH_TOKLO: begin
        back_dist = {token_hi[3:0], in_b} + 1;
        len       = token_hi[7:4] + lz77wd_pkg::LenBias;
        // Copy stops early when the stream reaches its size
        for (j = 0; j < len && produced_len != total_len; j++) begin
          if (back_dist <= produced_len) begin
            v   = window[WinAw'(win_wr_ptr - back_dist)];
            bad = 1'b0;
          end else begin
            v   = 8'h00;
            bad = 1'b1;
          end
          put_byte(v, bad);
          n++;
        end
        advance_flags();
      end
      default: begin
        // idle: drop the byte
      end
    endcase
    if (n != 0) decoded_q[decoded_q.size() - 1].run_last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------

  function automatic void push_byte(input logic [7:0] b, input logic start,
                                    input bit counted = 1'b1);
    compressed_q.push_back('{kind: EV_BYTE, data: b, start: start, send_pct: 0, recv_pct: 0});
    if (counted) stream_item_cnt++;
  endfunction

  // Drain all outstanding output, then switch idle and stall rates
  function automatic void push_hold(input int unsigned send_pct, input int unsigned recv_pct);
    compressed_q.push_back('{kind: EV_HOLD, data: 8'h00, start: 1'b0,
                             send_pct: send_pct, recv_pct: recv_pct});
  endfunction

  // Build one well-formed stream; a nonzero cut keeps only that many bytes after the marker
  function automatic void gen_stream(input int unsigned size, input int unsigned lit_pct,
                                     input int unsigned bad_pct, input int unsigned min_len,
                                     input int unsigned cut);
    logic [7:0]  body[$];
    logic [7:0]  flags;
    logic [11:0] dist_m1;
    logic [3:0]  len_m3;
    int unsigned made;
    int unsigned len;
    int unsigned back_dist;
    int unsigned reach;
    int unsigned k;
    body.push_back(size[7:0]);
    body.push_back(size[15:8]);
    body.push_back(size[23:16]);
    made = 0;
    while (made < size) begin
      for (k = 0; k < 8; k++) flags[k] = ($urandom_range(99) >= lit_pct);
      body.push_back(flags);
      for (k = 0; k < 8 && made < size; k++) begin
        if (!flags[7 - k]) begin
          body.push_back(8'($urandom_range(255)));
          made++;
        end else begin
          len   = $urandom_range(18, min_len);
          reach = (made < WinDepth) ? made : WinDepth;
          // Mostly reach into bytes already produced, sometimes before the start
          if (reach != 0 && $urandom_range(99) >= bad_pct) back_dist = $urandom_range(reach, 1);
          else back_dist = $urandom_range(WinDepth, 1);
          dist_m1 = 12'(back_dist - 1);
          len_m3  = 4'(len - 3);
          body.push_back({len_m3, dist_m1[11:8]});
          body.push_back(dist_m1[7:0]);
          made += (len < size - made) ? len : size - made;
        end
      end
    end
    push_byte(8'($urandom_range(255)), 1'b1);
    foreach (body[i]) begin
      if (cut == 0 || i < cut) push_byte(body[i], 1'b0);
    end
  endfunction

  // Random streams under one idle/stall setting
  function automatic void random_phase(input int unsigned send_pct, input int unsigned recv_pct,
                                       input int unsigned count);
    int unsigned goal;
    int unsigned size;
    int unsigned roll;
    int unsigned cut;
    int unsigned strays;
    push_hold(send_pct, recv_pct);
    goal = stream_item_cnt + count;
    while (stream_item_cnt < goal) begin
      roll = $urandom_range(99);
      if (roll < 6) size = 0;
      else if (roll < 90) size = $urandom_range(24, 1);
      else size = $urandom_range(160, 25);
      cut = ($urandom_range(99) < 12) ? $urandom_range(12, 1) : 0;
      gen_stream(size, $urandom_range(85, 15), $urandom_range(20, 0), 3, cut);
      // Stray bytes between streams
      if ($urandom_range(99) < 15) begin
        strays = $urandom_range(3, 1);
        repeat (strays) push_byte(8'($urandom_range(255)), 1'b0, 1'b0);
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: present queued bytes, honor holds and random sender gaps
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (compressed_q.size() == 0) begin
        s_axis_tvalid <= 1'b0;
      end else if (compressed_q[0].kind == EV_HOLD) begin
        s_axis_tvalid <= 1'b0;
        if (!s_axis_tvalid && quiet_cnt >= SettleCycles) begin
          send_idle_pct  <= compressed_q[0].send_pct;
          recv_stall_pct <= compressed_q[0].recv_pct;
          void'(compressed_q.pop_front());
        end
      end else if ($urandom_range(99) < send_idle_pct) begin
        s_axis_tvalid <= 1'b0;
      end else begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= compressed_q[0].data;
        s_axis_tuser  <= compressed_q[0].start;
        void'(compressed_q.pop_front());
      end
    end
  end

  // Receiver backpressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on input transactions, check output transactions
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_wr_ptr   = '0;
      total_len    = '0;
      produced_len = '0;
      flag_byte    = '0;
      flag_left    = '0;
      token_hi     = '0;
      parse_phase  = lz77wd_pkg::PH_IDLE;
      quiet_cnt   <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) decode_byte(s_axis_tdata, s_axis_tuser);
      if (m_axis_tvalid && m_axis_tready) begin
        beat_got = '{data: m_axis_tdata, run_last: m_axis_tlast,
                     stream_last: m_axis_tuser[0], bad_ref: m_axis_tuser[1]};
        if (decoded_q.size() == 0) begin
          $display("%0t: unexpected output: data=%02h last=%0b end=%0b bad=%0b", $time,
                   beat_got.data, beat_got.run_last, beat_got.stream_last, beat_got.bad_ref);
          mismatch_cnt++;
        end else begin
          beat_want = decoded_q.pop_front();
          if (beat_got.data !== beat_want.data || beat_got.run_last !== beat_want.run_last ||
              beat_got.stream_last !== beat_want.stream_last ||
              beat_got.bad_ref !== beat_want.bad_ref) begin
            $display("%0t: output mismatch: expected data=%02h last=%0b end=%0b bad=%0b",
                     $time, beat_want.data, beat_want.run_last, beat_want.stream_last,
                     beat_want.bad_ref);
            $display("%0t:                    got data=%02h last=%0b end=%0b bad=%0b",
                     $time, beat_got.data, beat_got.run_last, beat_got.stream_last,
                     beat_got.bad_ref);
            mismatch_cnt++;
          end
        end
      end
      // Count cycles with nothing in flight on either side
      if (s_axis_tvalid || m_axis_tvalid || decoded_q.size() != 0) quiet_cnt <= 0;
      else quiet_cnt <= quiet_cnt + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    // Bytes before any stream start are dropped
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    // Zero-size stream, then a trailing byte that is dropped
    push_byte(8'h10, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h5A, 1'b0);
    // Size 6: literal, then an 18-byte copy at distance 2 that starts before the
    // stream start and is cut short at the size; the trailing byte is dropped
    push_byte(8'h10, 1'b1);
    push_byte(8'h06, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h40, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hF0, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'hAB, 1'b0);
    // Largest size, longest copy at the farthest distance, all before the start;
    // the stream is then abandoned by the next stream start
    push_byte(8'h10, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);

    random_phase(0, 0, 75);
    random_phase(82, 0, 75);
    random_phase(0, 82, 75);
    random_phase(25, 25, 75);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (compressed_q.size() != 0 || s_axis_tvalid || quiet_cnt < SettleCycles) begin
      @(posedge clk_i);
    end
    if (decoded_q.size() != 0) begin
      $display("%0t: %0d output bytes never arrived", $time, decoded_q.size());
    end
    if (mismatch_cnt == 0 && decoded_q.size() == 0) begin
      $display("lz77_window_decoder_core regression: pass");
    end else begin
      $display("lz77_window_decoder_core regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(ClkPeriod * TimeoutCycles);
    $display("%0t: timeout", $time);
    $display("lz77_window_decoder_core regression: fail");
    $finish;
  end

endmodule
